### design/crl_pkg.sv
package crl_pkg;

    localparam int NumBackendsDef = 16;
    localparam int NumEntriesDef  = 256;
    localparam int ByteBitsDef    = 48;

    localparam int FuncW  = 3;
    localparam int BeW    = 4;
    localparam int IdW    = 8;
    localparam int GenW   = 16;
    localparam int StatW  = 3;
    localparam int TotW   = 52;
    localparam int PhaseW = 2;

    typedef enum logic [FuncW-1:0] {
        FN_REGISTER = 3'd0,
        FN_REFRESH  = 3'd1,
        FN_RESERVE  = 3'd2,
        FN_COMMIT   = 3'd3,
        FN_RELEASE  = 3'd4,
        FN_ADD      = 3'd5,
        FN_REMOVE   = 3'd6,
        FN_QUERY    = 3'd7
    } t_func;

    typedef enum logic [StatW-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INVALID   = 3'd2,
        ST_INSUFF    = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_BAD_STATE = 3'd5,
        ST_UNDERFLOW = 3'd6,
        ST_STALE     = 3'd7
    } t_status;

    typedef enum logic [PhaseW-1:0] {
        PH_ACTIVE    = 2'd0,
        PH_COMMITTED = 2'd1,
        PH_RELEASED  = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERD,
        S_BRD,
        S_A1,
        S_A2,
        S_A3,
        S_A4,
        S_DEC,
        S_UPD,
        S_U1,
        S_U2,
        S_U3,
        S_WR,
        S_OUT
    } t_state;

    // ALU operation codes
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB
    } t_aluop;

endpackage

### design/crl_ram.sv
module crl_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/crl_alu.sv
module crl_alu #(
    parameter int W = 64
) (
    input  crl_pkg::t_aluop i_op,
    input  logic [W-1:0]    i_a,
    input  logic [W-1:0]    i_b,
    output logic [W:0]      o_res
);
    import crl_pkg::*;

    // one wide add/sub; top bit is carry (add) or borrow (sub)
    always_comb begin
        unique case (i_op)
            ALU_ADD: o_res = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: o_res = {1'b0, i_a} - {1'b0, i_b};
            default: o_res = '0;
        endcase
    end
endmodule

### design/capacity_reservation_ledger.sv
// A sequencer steps each input through entry read, backend read, decode, arithmetic steps
// A1-A4, status update, update steps U1-U3 (only when the status is ok), memory write and
// output, running most adds, subtracts and compares through one shared wide ALU.
// One item at a time: the next input is taken only once the sequencer is back in idle,
// which waits while a held result keeps the sequencer from loading the output register.
// Reset (i_rst_n, synchronous, active low) clears presence bits, the id counter, totals,
// the allowance register and control state; memories hold data only and need no sweep.
module capacity_reservation_ledger #(
    parameter int NUM_BACKENDS = crl_pkg::NumBackendsDef,
    parameter int NUM_ENTRIES  = crl_pkg::NumEntriesDef,
    parameter int BYTE_BITS    = crl_pkg::ByteBitsDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [47:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // func[2:0], backend[6:3], amount[54:7], reclaim_amount[102:55],
    // reservation_id[110:103], generation[126:111], zero[127]
    input  logic [127:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // status[2:0], granted_id[10:3], rsv_bytes[58:11], cmt_bytes[106:59],
    // unused_bytes[154:107], rclm_bytes[202:155], total_reserved[254:203],
    // total_committed[306:255], zero[311:307]
    output logic [311:0]  m_axis_tdata
);
    import crl_pkg::*;

    localparam int BW  = (NUM_BACKENDS > 1) ? $clog2(NUM_BACKENDS) : 1;
    localparam int EW  = $clog2(NUM_ENTRIES);
    localparam int TW  = (BYTE_BITS + 4 > 64) ? 64 : BYTE_BITS + 4;
    localparam int AW  = (BYTE_BITS + 2 > TW) ? BYTE_BITS + 2 : TW;
    localparam logic [BYTE_BITS-1:0] BMAX = '1;
    localparam logic [TW-1:0]        TMAX = '1;
    localparam int RECW = 4 * BYTE_BITS;
    localparam int ENTW = BeW + BYTE_BITS + GenW + PhaseW;

    // input fields
    logic [FuncW-1:0] w_func;
    logic [BeW-1:0]   w_be;
    logic [47:0]      w_amt, w_rcl;
    logic [IdW-1:0]   w_rid;
    logic [GenW-1:0]  w_gen;
    assign w_func = s_axis_tdata[2:0];
    assign w_be   = s_axis_tdata[6:3];
    assign w_amt  = s_axis_tdata[54:7];
    assign w_rcl  = s_axis_tdata[102:55];
    assign w_rid  = s_axis_tdata[110:103];
    assign w_gen  = s_axis_tdata[126:111];

    t_state r_st, n_st;
    t_func  r_func;
    logic [BeW-1:0]       r_be;
    logic [BYTE_BITS-1:0] r_amt, r_rcl;
    logic [IdW-1:0]       r_rid;
    logic [GenW-1:0]      r_gen;
    logic [BYTE_BITS-1:0] r_allow;
    logic                 r_eok;
    logic [EW-1:0]        r_next_id;
    logic [TW-1:0]        r_sum_res, r_sum_com;
    logic [NUM_BACKENDS-1:0] r_bpres;
    logic [NUM_ENTRIES-1:0]  r_epres;

    // working registers
    logic [BYTE_BITS-1:0] r_free, r_res, r_com, r_rclm, r_ebytes;
    logic [GenW-1:0]      r_egen;
    logic [PhaseW-1:0]    r_ephase;
    logic [BeW-1:0]       r_tbe;    // reported backend
    logic                 r_bok;
    logic [AW:0]          r_t1;     // scratch with carry
    logic [AW:0]          r_t2;
    logic [StatW-1:0]     r_status;
    logic [EW-1:0]        r_id;
    logic [IdW-1:0]       r_granted;
    logic                 r_wb, r_we;
    logic [311:0]         r_out;
    logic                 r_ovalid;

    // memories
    logic [RECW-1:0] w_brd, w_bwd;
    logic [ENTW-1:0] w_erd, w_ewd;
    logic [BW-1:0]   w_baddr, w_braddr;
    logic [EW-1:0]   w_eaddr, w_erid;
    logic            w_bwe, w_ewe;

    assign w_erid  = EW'(r_rid);
    assign w_baddr = BW'(r_tbe);
    // commit and release read the record of the entry's backend as soon as the entry is in
    assign w_braddr = (r_st == S_BRD && (r_func == FN_COMMIT || r_func == FN_RELEASE)
                       && r_eok) ? BW'(w_erd[BeW-1:0]) : w_baddr;

    crl_ram #(.WIDTH(RECW), .DEPTH(NUM_BACKENDS)) u_bram (
        .i_clk(i_clk), .i_we(w_bwe), .i_waddr(w_baddr), .i_wdata(w_bwd),
        .i_raddr(w_braddr), .o_rdata(w_brd)
    );
    crl_ram #(.WIDTH(ENTW), .DEPTH(NUM_ENTRIES)) u_eram (
        .i_clk(i_clk), .i_we(w_ewe), .i_waddr(w_eaddr), .i_wdata(w_ewd),
        .i_raddr(w_erid), .o_rdata(w_erd)
    );

    assign w_bwd = {r_rclm, r_com, r_res, r_free};
    assign w_ewd = {r_ephase, r_egen, r_ebytes, r_tbe};
    assign w_bwe = (r_st == S_WR) && r_wb;
    assign w_ewe = (r_st == S_WR) && r_we;
    assign w_eaddr = (r_func == FN_RESERVE) ? r_id : w_erid;

    // shared ALU
    t_aluop      w_op;
    logic [AW-1:0] w_a, w_b;
    logic [AW:0]   w_y;
    crl_alu #(.W(AW)) u_alu (.i_op(w_op), .i_a(w_a), .i_b(w_b), .o_res(w_y));

    function automatic logic [AW-1:0] zx(input logic [BYTE_BITS-1:0] v);
        return AW'(v);
    endfunction
    function automatic logic [AW-1:0] zt(input logic [TW-1:0] v);
        return AW'(v);
    endfunction

    logic w_bpres;
    assign w_bpres = r_bok && r_bpres[w_baddr];

    // ALU operand select per step
    always_comb begin
        w_op = ALU_ADD;
        w_a  = '0;
        w_b  = '0;
        unique case (r_st)
            S_A1: begin  // res + com
                w_a = zx(r_res); w_b = zx(r_com);
            end
            S_A2: begin
                unique case (r_func)
                    FN_RESERVE: begin w_a = r_t1[AW-1:0]; w_b = zx(r_amt); end
                    FN_COMMIT, FN_RELEASE: begin
                        w_op = ALU_SUB; w_a = zx(r_res); w_b = zx(r_ebytes);
                    end
                    FN_ADD: begin w_a = zx(r_com); w_b = zx(r_amt); end
                    FN_REMOVE: begin
                        w_op = ALU_SUB; w_a = zx(r_com); w_b = zx(r_amt);
                    end
                    default: ;
                endcase
            end
            S_A3: begin  // free + allowance
                w_a = zx(r_free); w_b = zx(r_allow);
            end
            S_A4: begin  // compare occupancy against headroom
                w_op = ALU_SUB; w_a = r_t2[AW-1:0]; w_b = r_t1[AW-1:0];
            end
            S_U1: begin
                unique case (r_func)
                    FN_RESERVE: begin w_a = zx(r_res); w_b = zx(r_amt); end
                    FN_COMMIT: begin w_a = zx(r_com); w_b = zx(r_ebytes); end
                    FN_ADD: begin w_a = zx(r_com); w_b = zx(r_amt); end
                    default: ;
                endcase
            end
            S_U2: begin
                unique case (r_func)
                    FN_RESERVE: begin w_a = zt(r_sum_res); w_b = zx(r_amt); end
                    FN_COMMIT, FN_RELEASE: begin
                        w_op = ALU_SUB; w_a = zt(r_sum_res); w_b = zx(r_ebytes);
                    end
                    FN_ADD: begin w_a = zt(r_sum_com); w_b = zx(r_amt); end
                    FN_REMOVE: begin
                        w_op = ALU_SUB; w_a = zt(r_sum_com); w_b = zx(r_amt);
                    end
                    default: ;
                endcase
            end
            S_U3: begin
                w_a = zt(r_sum_com); w_b = zx(r_ebytes);
            end
            S_OUT: begin  // unused: free - (res + com)
                w_op = ALU_SUB; w_a = zx(r_free); w_b = r_t1[AW-1:0];
            end
            default: ;
        endcase
    end

    // saturating helpers on ALU result
    function automatic logic [BYTE_BITS-1:0] bsat(input logic [AW:0] y);
        logic [AW:0] m;
        m = (AW+1)'(BMAX);
        return (y > m) ? BMAX : y[BYTE_BITS-1:0];
    endfunction
    function automatic logic [TW-1:0] tsat(input logic [AW:0] y);
        logic [AW:0] m;
        m = (AW+1)'(TMAX);
        return (y > m) ? TMAX : y[TW-1:0];
    endfunction
    function automatic logic [TW-1:0] tflr(input logic [AW:0] y);
        return y[AW] ? '0 : y[TW-1:0];
    endfunction

    assign s_axis_tready = (r_st == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (s_axis_tvalid) n_st = S_ERD;
            S_ERD:  n_st = S_BRD;
            S_BRD:  n_st = S_DEC;
            S_DEC:  n_st = S_A1;
            S_A1:   n_st = S_A2;
            S_A2:   n_st = S_A3;
            S_A3:   n_st = S_A4;
            S_A4:   n_st = S_UPD;
            S_UPD:  n_st = (r_status == ST_OK) ? S_U1 : S_WR;
            S_U1:   n_st = S_U2;
            S_U2:   n_st = S_U3;
            S_U3:   n_st = S_WR;
            S_WR:   n_st = S_OUT;
            S_OUT:  if (!r_ovalid || m_axis_tready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_allow   <= '0;
            r_next_id <= '0;
            r_sum_res <= '0;
            r_sum_com <= '0;
            r_bpres   <= '0;
            r_epres   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid) r_allow <= BYTE_BITS'(i_cfg_data);
            if (r_st == S_OUT && (!r_ovalid || m_axis_tready)) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (s_axis_tvalid) begin
                    r_func <= t_func'(w_func);
                    r_be   <= w_be;
                    r_amt  <= BYTE_BITS'(w_amt);
                    r_rcl  <= BYTE_BITS'(w_rcl);
                    r_rid  <= w_rid;
                    r_gen  <= w_gen;
                end
                S_ERD: begin
                    // entry read in flight; pick the backend to report
                    r_eok <= (32'(r_rid) < NUM_ENTRIES) && r_epres[w_erid];
                    r_tbe <= r_be;
                    r_bok <= 32'(r_be) < NUM_BACKENDS;
                    r_wb  <= 1'b0;
                    r_we  <= 1'b0;
                    r_granted <= '0;
                    r_status  <= ST_OK;
                end
                S_BRD: begin
                    {r_ephase, r_egen, r_ebytes} <= w_erd[ENTW-1:BeW];
                    if ((r_func == FN_COMMIT || r_func == FN_RELEASE) && r_eok) begin
                        r_tbe <= w_erd[BeW-1:0];
                        r_bok <= 32'(w_erd[BeW-1:0]) < NUM_BACKENDS;
                    end
                end
                S_DEC: begin
                    // backend record now valid for r_tbe
                    {r_rclm, r_com, r_res, r_free} <= w_brd;
                end
                S_A1: r_t1 <= w_y;
                S_A2: r_t1 <= (r_func == FN_RESERVE) ? w_y : r_t1;
                S_A3: r_t2 <= w_y;
                S_A4: begin
                    // decide status; w_y[AW] set means occupancy > headroom
                    unique case (r_func)
                        FN_REGISTER: begin
                            if (r_bok) begin
                                r_free <= r_amt; r_rclm <= r_rcl;
                                r_res <= '0; r_com <= '0; r_wb <= 1'b1;
                                r_bpres[w_baddr] <= 1'b1;
                            end
                        end
                        FN_REFRESH: begin
                            if (w_bpres) begin r_free <= r_amt; r_wb <= 1'b1; end
                            else r_status <= ST_NOT_FOUND;
                        end
                        FN_RESERVE: begin
                            if (!w_bpres) r_status <= ST_NOT_FOUND;
                            else if (r_amt == '0) r_status <= ST_INVALID;
                            else if (w_y[AW]) r_status <= ST_INSUFF;
                            else begin
                                r_id <= r_next_id;
                                r_next_id <= (32'(r_next_id) == NUM_ENTRIES - 1) ? '0
                                                                               : r_next_id + 1'b1;
                                if (r_epres[r_next_id]) r_status <= ST_DUPLICATE;
                            end
                        end
                        FN_COMMIT: begin
                            if (!r_eok) r_status <= ST_NOT_FOUND;
                            else if (r_ephase != PH_ACTIVE) r_status <= ST_BAD_STATE;
                            else if (!w_bpres) r_status <= ST_NOT_FOUND;
                            else if (r_res < r_ebytes) r_status <= ST_UNDERFLOW;
                        end
                        FN_RELEASE: begin
                            if (!r_eok) r_status <= ST_STALE;
                            else if (r_ephase == PH_RELEASED) r_status <= ST_DUPLICATE;
                            else if (r_egen != r_gen) r_status <= ST_STALE;
                            else if (r_ephase != PH_ACTIVE) r_status <= ST_BAD_STATE;
                            else if (!w_bpres) r_status <= ST_NOT_FOUND;
                            else if (r_res < r_ebytes) r_status <= ST_UNDERFLOW;
                        end
                        FN_ADD: if (!w_bpres) r_status <= ST_NOT_FOUND;
                        FN_REMOVE: begin
                            if (!w_bpres) r_status <= ST_NOT_FOUND;
                            else if (r_com < r_amt) r_status <= ST_UNDERFLOW;
                        end
                        FN_QUERY: if (!w_bpres) r_status <= ST_NOT_FOUND;
                        default: ;
                    endcase
                end
                S_UPD: begin
                    // only register/refresh/query skip arithmetic updates
                    if (r_status == ST_OK && (r_func == FN_RESERVE)) begin
                        r_epres[r_id] <= 1'b1;
                        r_egen   <= r_gen;
                        r_ebytes <= r_amt;
                        r_ephase <= PH_ACTIVE;
                        r_granted <= IdW'(r_id);
                        r_we <= 1'b1;
                        r_wb <= 1'b1;
                    end
                    if (r_status == ST_OK && r_func != FN_REGISTER && r_func != FN_REFRESH
                        && r_func != FN_QUERY && r_func != FN_RESERVE) begin
                        r_wb <= 1'b1;
                    end
                end
                S_U1: begin
                    unique case (r_func)
                        FN_RESERVE: r_res <= bsat(w_y);
                        FN_COMMIT, FN_ADD: r_com <= bsat(w_y);
                        default: ;
                    endcase
                    if (r_func == FN_COMMIT || r_func == FN_RELEASE)
                        r_res <= r_res - r_ebytes;
                    if (r_func == FN_REMOVE) r_com <= r_com - r_amt;
                    if (r_func == FN_COMMIT) r_ephase <= PH_COMMITTED;
                    if (r_func == FN_RELEASE) begin
                        r_ephase <= PH_RELEASED; r_we <= 1'b1;
                    end
                    if (r_func == FN_COMMIT) r_we <= 1'b1;
                end
                S_U2: begin
                    unique case (r_func)
                        FN_RESERVE: r_sum_res <= tsat(w_y);
                        FN_COMMIT, FN_RELEASE: r_sum_res <= tflr(w_y);
                        FN_ADD: r_sum_com <= tsat(w_y);
                        FN_REMOVE: r_sum_com <= tflr(w_y);
                        default: ;
                    endcase
                end
                S_U3: if (r_func == FN_COMMIT) r_sum_com <= tsat(w_y);
                S_WR: begin
                    r_wb <= 1'b0;
                    r_we <= 1'b0;
                    // occupancy for unused_bytes
                    r_t1 <= {1'b0, zx(r_res)} + {1'b0, zx(r_com)};
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_out <= {5'b0, TotW'(r_sum_com), TotW'(r_sum_res),
                                  w_bpres ? 48'(r_rclm) : 48'd0,
                                  (w_bpres && !w_y[AW]) ? 48'(w_y[BYTE_BITS-1:0]) : 48'd0,
                                  w_bpres ? 48'(r_com) : 48'd0,
                                  w_bpres ? 48'(r_res) : 48'd0,
                                  r_granted, r_status};
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
